>>> rtl/irk_pkg.sv
// Package for the increasing word ranker: sizes, character bounds, the entry
// that travels from the front end to the back end, and the binomial tables.
// No dependencies.
package irk_pkg;

  localparam int unsigned NumChars     = 5;
  localparam int unsigned MaxWordLen   = 5;
  localparam int unsigned CharW        = 8;
  localparam int unsigned LenW         = 3;
  localparam int unsigned LetterW      = 5;
  localparam int unsigned RankW        = 17;
  localparam int unsigned AlphaSize    = 26;
  localparam int unsigned TotalWords   = 83681;
  localparam int unsigned FifoDepthDef = 2;

  localparam logic [CharW-1:0] LowChar  = 8'h61;  // 'a'
  localparam logic [CharW-1:0] HighChar = 8'h7a;  // 'z'

  typedef logic [LetterW-1:0] letter_t;

  // Classified word: ok clear means the result is zero.
  typedef struct packed {
    logic                         ok;
    logic [LenW-1:0]              len;
    letter_t [NumChars-1:0]       letters;
  } irk_entry_t;

  // C(n, k) for n = 0..26, one row per k
  localparam logic [RankW-1:0] C2Tab [27] = '{
    17'd0, 17'd0, 17'd1, 17'd3, 17'd6, 17'd10, 17'd15, 17'd21, 17'd28,
    17'd36, 17'd45, 17'd55, 17'd66, 17'd78, 17'd91, 17'd105, 17'd120,
    17'd136, 17'd153, 17'd171, 17'd190, 17'd210, 17'd231, 17'd253,
    17'd276, 17'd300, 17'd325
  };

  localparam logic [RankW-1:0] C3Tab [27] = '{
    17'd0, 17'd0, 17'd0, 17'd1, 17'd4, 17'd10, 17'd20, 17'd35, 17'd56,
    17'd84, 17'd120, 17'd165, 17'd220, 17'd286, 17'd364, 17'd455, 17'd560,
    17'd680, 17'd816, 17'd969, 17'd1140, 17'd1330, 17'd1540, 17'd1771,
    17'd2024, 17'd2300, 17'd2600
  };

  localparam logic [RankW-1:0] C4Tab [27] = '{
    17'd0, 17'd0, 17'd0, 17'd0, 17'd1, 17'd5, 17'd15, 17'd35, 17'd70,
    17'd126, 17'd210, 17'd330, 17'd495, 17'd715, 17'd1001, 17'd1365,
    17'd1820, 17'd2380, 17'd3060, 17'd3876, 17'd4845, 17'd5985, 17'd7315,
    17'd8855, 17'd10626, 17'd12650, 17'd14950
  };

  localparam logic [RankW-1:0] C5Tab [27] = '{
    17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd1, 17'd6, 17'd21, 17'd56,
    17'd126, 17'd252, 17'd462, 17'd792, 17'd1287, 17'd2002, 17'd3003,
    17'd4368, 17'd6188, 17'd8568, 17'd11628, 17'd15504, 17'd20349,
    17'd26334, 17'd33649, 17'd42504, 17'd53130, 17'd65780
  };

  // Binomial C(n, k) for n up to 26 and k from 1 to 5; zero elsewhere.
  function automatic logic [RankW-1:0] choose(input logic [LetterW-1:0] n,
                                              input logic [LenW-1:0] k);
    logic [RankW-1:0] r;
    r = '0;
    if (n <= LetterW'(AlphaSize)) begin
      unique case (k)
        3'd1:    r = RankW'(n);
        3'd2:    r = C2Tab[n];
        3'd3:    r = C3Tab[n];
        3'd4:    r = C4Tab[n];
        3'd5:    r = C5Tab[n];
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  // Count of all increasing words shorter than len.
  function automatic logic [RankW-1:0] base_rank(input logic [LenW-1:0] len);
    logic [RankW-1:0] r;
    unique case (len)
      3'd2:    r = 17'd26;
      3'd3:    r = 17'd351;
      3'd4:    r = 17'd2951;
      3'd5:    r = 17'd17901;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/irk_fifo.sv
// Small register queue between the front end and the back end.
// Generic width and depth; no package dependency.
module irk_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);

endmodule

>>> rtl/irk_front.sv
// Front end: checks length and characters of a word and turns each used
// character into a letter index. Depends on irk_pkg.
module irk_front import irk_pkg::*; (
  input  logic [LenW-1:0]                 word_length_i,
  input  logic [NumChars-1:0][CharW-1:0]  chars_i,
  output irk_entry_t                      entry_o
);

  logic [NumChars-1:0][CharW-1:0] offset;
  logic [NumChars-1:0]            used;
  logic [NumChars-1:0]            in_range;

  always_comb begin
    entry_o.ok  = (word_length_i != '0) && (word_length_i <= LenW'(MaxWordLen));
    entry_o.len = word_length_i;
    for (int i = 0; i < NumChars; i++) begin
      used[i]     = (LenW'(i) < word_length_i);
      in_range[i] = (chars_i[i] >= LowChar) && (chars_i[i] <= HighChar);
      offset[i]   = chars_i[i] - LowChar;
      entry_o.letters[i] = in_range[i] ? offset[i][LetterW-1:0] : '0;
      if (used[i] && !in_range[i]) begin
        entry_o.ok = 1'b0;
      end
      // drop words whose used characters do not strictly rise
      if (i > 0) begin
        if (used[i] && (chars_i[i] <= chars_i[i-1])) begin
          entry_o.ok = 1'b0;
        end
      end
    end
  end

endmodule

>>> rtl/irk_back.sv
// Back end: two-stage rank pipeline. Stage one looks up one binomial
// difference per character, stage two adds them up. Depends on irk_pkg.
module irk_back import irk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  irk_entry_t       entry_i,
  output logic             result_valid_o,
  output logic [RankW-1:0] word_position_o
);

  logic [NumChars-1:0][LetterW-1:0] prev;
  logic [NumChars-1:0][LenW-1:0]    rest;
  logic [NumChars-1:0][RankW-1:0]   term_d, term_q;
  logic [RankW-1:0]                 base_d, base_q;
  logic                             ok_q;
  logic                             s1_valid_q;
  logic [RankW-1:0]                 sum;
  logic [RankW-1:0]                 pos_d, pos_q;
  logic                             out_valid_q;

  // Words below this one at the same length, position by position:
  // sum of C(25-v, rest-1) for v in [prev, cur) equals C(26-prev, rest) - C(26-cur, rest).
  always_comb begin
    base_d = base_rank(entry_i.len);
    for (int i = 0; i < NumChars; i++) begin
      prev[i] = (i == 0) ? '0 : entry_i.letters[(i > 0) ? i - 1 : 0] + 1'b1;
      rest[i] = entry_i.len - LenW'(i);
      if (entry_i.ok && (LenW'(i) < entry_i.len)) begin
        term_d[i] = choose(LetterW'(AlphaSize) - prev[i], rest[i])
                  - choose(LetterW'(AlphaSize) - entry_i.letters[i], rest[i]);
      end else begin
        term_d[i] = '0;
      end
    end
  end

  always_comb begin
    sum = base_q;
    for (int i = 0; i < NumChars; i++) begin
      sum = sum + term_q[i];
    end
    pos_d = ok_q ? sum + 1'b1 : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= valid_i;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
    base_q <= base_d;
    ok_q   <= entry_i.ok;
    pos_q  <= pos_d;
  end

  assign result_valid_o  = out_valid_q;
  assign word_position_o = pos_q;

endmodule

>>> rtl/increasing_word_rank.sv
// Increasing word ranker, top level.
// Depends on irk_pkg, irk_front, irk_fifo and irk_back.
//
// Usage:
//   A word is offered on word_length_i and char_*_i with start held high; it
//   is taken at a rising edge where start is high and busy is low. The result
//   word_position_o is the 1-based rank of the word among all strictly rising
//   lower-case words of 1 to 5 letters (by length, then alphabetically), or
//   zero when the word is not such a word. It shows for exactly one cycle,
//   marked by result_valid_o.
//   Path: the word passes the queue, then the register of table lookups,
//   then the register of adds, whose valid bit drives the strobe.
//   Throughput: one word per cycle; the back end drains the queue every
//   cycle, so busy stays low in normal use and only rises if the queue fills.
//   Reset clears the queue and the pipeline valid bits; words in flight are
//   dropped. The receiver has no stall, so results are never held back.
module increasing_word_rank import irk_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [LenW-1:0]  word_length_i,
  input  logic [CharW-1:0] char_first_i,
  input  logic [CharW-1:0] char_second_i,
  input  logic [CharW-1:0] char_third_i,
  input  logic [CharW-1:0] char_fourth_i,
  input  logic [CharW-1:0] char_fifth_i,
  output logic             result_valid_o,
  output logic [RankW-1:0] word_position_o
);

  logic [NumChars-1:0][CharW-1:0] chars;
  irk_entry_t                     front_entry;
  irk_entry_t                     back_entry;
  logic [$bits(irk_entry_t)-1:0]  fifo_rdata;
  logic                           push;
  logic                           pop;
  logic                           fifo_full;
  logic                           fifo_empty;

  assign chars = {char_fifth_i, char_fourth_i, char_third_i, char_second_i, char_first_i};

  assign busy = fifo_full;
  assign push = start && !busy;
  assign pop  = !fifo_empty;

  irk_front u_front (
    .word_length_i (word_length_i),
    .chars_i       (chars),
    .entry_o       (front_entry)
  );

  irk_fifo #(
    .Width ($bits(irk_entry_t)),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_entry),
    .pop_i   (pop),
    .data_o  (fifo_rdata),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  assign back_entry = irk_entry_t'(fifo_rdata);

  irk_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (pop),
    .entry_i         (back_entry),
    .result_valid_o  (result_valid_o),
    .word_position_o (word_position_o)
  );

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 result_valid_o)
    else $error("accepted word produced no result");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 3))
    else $error("result without matching accepted word");

  a_rank_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (word_position_o <= RankW'(TotalWords)))
    else $error("rank beyond word count");
`endif

endmodule
